@@ design/hnm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants of the histogram nearest-match block: opcodes,
// beat layouts of the item and result channels, and fixed field widths.
// ----------------------------------------------------------------------------
package hnm_pkg;

  // fixed field widths of the channel beats
  localparam int OPC_W = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 16;
  localparam int LBL_W = 8;
  localparam int OVL_W = 26;
  localparam int DST_W = 42;

  // defaults for the top-level parameters
  localparam int NUM_BINS_DEF   = 1024;
  localparam int COUNT_BITS_DEF = 16;
  localparam int LABEL_BITS_DEF = 8;

  // saturation ceilings of the running sums
  localparam logic [OVL_W-1:0] OVL_MAX = '1;
  localparam logic [DST_W-1:0] DST_MAX = '1;

  // item opcodes
  typedef enum logic [OPC_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TRAIN = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // item beat
  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [IDX_W-1:0] bin_index;
    logic [VAL_W-1:0] bin_value;
    logic [LBL_W-1:0] class_label;
    logic             last_bin;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [LBL_W-1:0] overlap_label;
    logic [OVL_W-1:0] overlap_score;
    logic [LBL_W-1:0] closest_label;
    logic [DST_W-1:0] closest_sq_distance;
  } out_beat_t;

endpackage
`default_nettype wire

@@ design/hnm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_ram
// Generic single-port synchronous RAM, one access per cycle, registered read
// data that holds until the next read.
// ----------------------------------------------------------------------------
module hnm_ram #(
  parameter int WIDTH = hnm_pkg::COUNT_BITS_DEF,
  parameter int DEPTH = hnm_pkg::NUM_BINS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

@@ design/histogram_nearest_match_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_nearest_match_top
// Query histogram store with streaming intersection and squared-distance
// scoring of training histograms; keeps and reports the best-matching labels.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle of every opcode when not stalled. Query
// bins are written into a single-port RAM as they arrive; training bins read it
// back and flow through a five-stage pipeline (RAM read, min and absolute
// difference, square, saturating accumulate, best-match compare). A result
// beat is presented from the output register once the last_bin beat passes stage 4.
// A clear travels the same pipeline, so it acts in order with the beats around it.
// While a result waits in the output register and out_stall is high, the
// whole pipeline holds and in_stall is raised. The query store has no reset
// and needs no clearing pass; training bins may only read bins already loaded.
module histogram_nearest_match_top #(
  parameter int NUM_BINS   = hnm_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = hnm_pkg::COUNT_BITS_DEF,
  parameter int LABEL_BITS = hnm_pkg::LABEL_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire hnm_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hnm_pkg::out_beat_t     out_data
);

  localparam int AW   = $clog2(NUM_BINS);
  localparam int QW   = (COUNT_BITS < hnm_pkg::VAL_W) ? COUNT_BITS : hnm_pkg::VAL_W;
  localparam int LW   = (LABEL_BITS < hnm_pkg::LBL_W) ? LABEL_BITS : hnm_pkg::LBL_W;
  localparam int SQ_W = 2 * QW;
  localparam int OW   = hnm_pkg::OVL_W;
  localparam int DW   = hnm_pkg::DST_W;

  // global advance: hold everything while a result waits downstream
  logic adv;
  logic accept;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // decode of the incoming beat
  logic          is_load;
  logic          is_train;
  logic          is_clear;
  logic [31:0]   idx_w;
  logic [31:0]   val_w;
  logic [31:0]   lab_w;
  logic          in_range;
  logic [AW-1:0] ram_addr;
  logic [QW-1:0] val_q;
  logic [LW-1:0] lab_q;

  assign is_load  = in_data.opcode == hnm_pkg::OP_LOAD;
  assign is_train = in_data.opcode == hnm_pkg::OP_TRAIN;
  assign is_clear = in_data.opcode == hnm_pkg::OP_CLEAR;
  assign idx_w    = 32'(in_data.bin_index);
  assign val_w    = 32'(in_data.bin_value);
  assign lab_w    = 32'(in_data.class_label);
  assign in_range = idx_w < 32'(NUM_BINS);
  assign ram_addr = idx_w[AW-1:0];
  assign val_q    = val_w[QW-1:0];
  assign lab_q    = lab_w[LW-1:0];

  // query store
  logic          ram_en;
  logic          ram_we;
  logic [QW-1:0] ram_rdata;

  assign ram_we = accept && is_load && in_range;
  assign ram_en = ram_we || (accept && is_train);

  hnm_ram #(
    .WIDTH(QW),
    .DEPTH(NUM_BINS)
  ) u_query_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(val_q),
    .rdata(ram_rdata)
  );

  // stage 1: waiting on the store read
  logic          s1_v_r;
  logic          s1_clr_r;
  logic          s1_last_r;
  logic          s1_inr_r;
  logic [LW-1:0] s1_lab_r;
  logic [QW-1:0] s1_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= accept && (is_train || is_clear);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_clr_r  <= is_clear;
      s1_last_r <= in_data.last_bin;
      s1_inr_r  <= in_range;
      s1_lab_r  <= lab_q;
      s1_val_r  <= val_q;
    end
  end

  // stage 1 logic: per-bin minimum and absolute difference
  logic [QW-1:0] q_val;
  logic [QW-1:0] bin_min;
  logic [QW-1:0] bin_diff;

  always_comb begin
    q_val    = s1_inr_r ? ram_rdata : '0;
    bin_min  = (q_val <= s1_val_r) ? q_val : s1_val_r;
    bin_diff = (q_val >= s1_val_r) ? (q_val - s1_val_r) : (s1_val_r - q_val);
  end

  // stage 2: square of the difference
  logic          s2_v_r;
  logic          s2_clr_r;
  logic          s2_last_r;
  logic [LW-1:0] s2_lab_r;
  logic [QW-1:0] s2_min_r;
  logic [QW-1:0] s2_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_clr_r  <= s1_clr_r;
      s2_last_r <= s1_last_r;
      s2_lab_r  <= s1_lab_r;
      s2_min_r  <= bin_min;
      s2_diff_r <= bin_diff;
    end
  end

  logic [SQ_W-1:0] diff_sq;
  assign diff_sq = SQ_W'(s2_diff_r) * SQ_W'(s2_diff_r);

  // stage 3: saturating accumulation
  logic            s3_v_r;
  logic            s3_clr_r;
  logic            s3_last_r;
  logic [LW-1:0]   s3_lab_r;
  logic [QW-1:0]   s3_min_r;
  logic [SQ_W-1:0] s3_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_clr_r  <= s2_clr_r;
      s3_last_r <= s2_last_r;
      s3_lab_r  <= s2_lab_r;
      s3_min_r  <= s2_min_r;
      s3_sq_r   <= diff_sq;
    end
  end

  logic [OW-1:0] ovl_acc_r;
  logic [OW-1:0] ovl_acc_nxt;
  logic [DW-1:0] dst_acc_r;
  logic [DW-1:0] dst_acc_nxt;
  logic [OW:0]   ovl_sum;
  logic [DW:0]   dst_sum;
  logic [OW-1:0] ovl_add;
  logic [DW-1:0] dst_add;

  // sums clip at the top of their widths
  always_comb begin
    ovl_sum = {1'b0, ovl_acc_r} + (OW + 1)'(s3_min_r);
    dst_sum = {1'b0, dst_acc_r} + (DW + 1)'(s3_sq_r);
    ovl_add = ovl_sum[OW] ? hnm_pkg::OVL_MAX : ovl_sum[OW-1:0];
    dst_add = dst_sum[DW] ? hnm_pkg::DST_MAX : dst_sum[DW-1:0];
  end

  // a last bin or a clear restarts the sums
  always_comb begin
    ovl_acc_nxt = ovl_acc_r;
    dst_acc_nxt = dst_acc_r;
    if (adv && s3_v_r) begin
      if (s3_clr_r || s3_last_r) begin
        ovl_acc_nxt = '0;
        dst_acc_nxt = '0;
      end else begin
        ovl_acc_nxt = ovl_add;
        dst_acc_nxt = dst_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_acc_r <= '0;
      dst_acc_r <= '0;
    end else begin
      ovl_acc_r <= ovl_acc_nxt;
      dst_acc_r <= dst_acc_nxt;
    end
  end

  // stage 4: finished histogram scores or a clear
  logic          s4_v_r;
  logic          s4_clr_r;
  logic [LW-1:0] s4_lab_r;
  logic [OW-1:0] s4_ovl_r;
  logic [DW-1:0] s4_dst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r && (s3_clr_r || s3_last_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_clr_r <= s3_clr_r;
      s4_lab_r <= s3_lab_r;
      s4_ovl_r <= ovl_add;
      s4_dst_r <= dst_add;
    end
  end

  // best matches
  logic [OW-1:0] best_ovl_r;
  logic [OW-1:0] best_ovl_nxt;
  logic [LW-1:0] best_ovl_lab_r;
  logic [LW-1:0] best_ovl_lab_nxt;
  logic [DW-1:0] best_dst_r;
  logic [DW-1:0] best_dst_nxt;
  logic [LW-1:0] best_dst_lab_r;
  logic [LW-1:0] best_dst_lab_nxt;
  logic          dst_seen_r;
  logic          dst_seen_nxt;
  logic          ovl_win;
  logic          dst_win;
  logic          s4_fire;

  assign s4_fire = adv && s4_v_r;
  assign ovl_win = s4_ovl_r >= best_ovl_r;
  assign dst_win = !dst_seen_r || (s4_dst_r <= best_dst_r);

  // later histogram wins ties; first one after a clear always takes distance
  always_comb begin
    best_ovl_nxt     = best_ovl_r;
    best_ovl_lab_nxt = best_ovl_lab_r;
    best_dst_nxt     = best_dst_r;
    best_dst_lab_nxt = best_dst_lab_r;
    dst_seen_nxt     = dst_seen_r;
    if (s4_fire) begin
      if (s4_clr_r) begin
        best_ovl_nxt     = '0;
        best_ovl_lab_nxt = '0;
        best_dst_nxt     = '0;
        best_dst_lab_nxt = '0;
        dst_seen_nxt     = 1'b0;
      end else begin
        if (ovl_win) begin
          best_ovl_nxt     = s4_ovl_r;
          best_ovl_lab_nxt = s4_lab_r;
        end
        if (dst_win) begin
          best_dst_nxt     = s4_dst_r;
          best_dst_lab_nxt = s4_lab_r;
          dst_seen_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_ovl_r     <= '0;
      best_ovl_lab_r <= '0;
      best_dst_r     <= '0;
      best_dst_lab_r <= '0;
      dst_seen_r     <= 1'b0;
    end else begin
      best_ovl_r     <= best_ovl_nxt;
      best_ovl_lab_r <= best_ovl_lab_nxt;
      best_dst_r     <= best_dst_nxt;
      best_dst_lab_r <= best_dst_lab_nxt;
      dst_seen_r     <= dst_seen_nxt;
    end
  end

  // output register
  logic               out_valid_r;
  logic               out_valid_nxt;
  hnm_pkg::out_beat_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s4_fire && !s4_clr_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_fire && !s4_clr_r) begin
      out_data_r.overlap_label       <= hnm_pkg::LBL_W'(best_ovl_lab_nxt);
      out_data_r.overlap_score       <= best_ovl_nxt;
      out_data_r.closest_label       <= hnm_pkg::LBL_W'(best_dst_lab_nxt);
      out_data_r.closest_sq_distance <= best_dst_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("item taken while a result is blocked");

  a_sums_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_v_r && (s3_last_r || s3_clr_r)) |=> (ovl_acc_r == '0 && dst_acc_r == '0))
    else $error("running sums not restarted after last bin or clear");

  a_clear_forgets: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_fire && s4_clr_r) |=> (!dst_seen_r && best_ovl_r == '0 && !out_valid_r))
    else $error("clear did not forget best matches");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s4_v_r && !s4_clr_r))
    else $error("result raised without a finished histogram");

endmodule
`default_nettype wire
